FILE: rtl/core/evcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package evcp_pkg;

  localparam int unsigned SLEEP_TIMEOUT_MS_DEF = 3000;
  localparam int unsigned DUTY_FULL_DEF        = 255;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_A_B    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_B_C    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_C_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TO_A    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OTHER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MID      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BOOST    = 3'd7;

  localparam logic [11:0] THRESH_A_B_RST   = 12'd3000;
  localparam logic [11:0] THRESH_B_C_RST   = 12'd2500;
  localparam logic [11:0] THRESH_C_D_RST   = 12'd2000;
  localparam logic [15:0] DELAY_TO_A_RST   = 16'd100;
  localparam logic [15:0] DELAY_OTHER_RST  = 16'd100;
  localparam logic [7:0]  DUTY_LOW_RST     = 8'd34;
  localparam logic [7:0]  DUTY_MID_RST     = 8'd68;
  localparam logic [7:0]  DUTY_BOOST_RST   = 8'd128;

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_ENABLE = 2'd1;
  localparam logic [1:0] ACT_SPEED  = 2'd2;

  typedef enum logic [1:0] {
    ST_A     = 2'd0,
    ST_B     = 2'd1,
    ST_C     = 2'd2,
    ST_SLEEP = 2'd3
  } cp_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_ms;
    logic [11:0] pilot_peak;
    logic        button_low;
    logic        button_mid;
    logic        button_boost;
    logic        enable_value;
    logic [7:0]  speed_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       relay_on;
    logic [1:0] state_code;
    logic       changed;
    logic [1:0] prior_state;
    logic       released_by_timeout;
  } out_item_t;

  typedef struct packed {
    logic [11:0] thresh_a_b;
    logic [11:0] thresh_b_c;
    logic [11:0] thresh_c_d;
    logic [15:0] delay_to_a_ms;
    logic [15:0] delay_other_ms;
    logic [7:0]  duty_low_rate;
    logic [7:0]  duty_mid_rate;
    logic [7:0]  duty_boost_rate;
  } cfg_t;

  typedef struct packed {
    cp_state_t   current_state;
    cp_state_t   measured_state;
    cp_state_t   last_seen_state;
    cp_state_t   pending_state;
    logic [31:0] pending_start_ms;
    logic [31:0] sleep_start_ms;
    logic [7:0]  charge_duty;
    logic        charge_enabled;
    logic [7:0]  duty_out;
    logic        relay_state;
  } cp_ctx_t;

endpackage
`default_nettype wire

FILE: rtl/core/evcp_step.sv
`timescale 1ns / 1ps
`default_nettype none
module evcp_step import evcp_pkg::*; #(
  parameter int unsigned SLEEP_TIMEOUT_MS = SLEEP_TIMEOUT_MS_DEF,
  parameter int unsigned DUTY_FULL        = DUTY_FULL_DEF
) (
  input  cp_ctx_t   ctx_i,
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  output cp_ctx_t   ctx_o,
  output out_item_t res_o
);

  localparam logic [31:0] SLEEP_TO = 32'(SLEEP_TIMEOUT_MS);
  localparam logic [7:0]  FULL     = 8'(DUTY_FULL);

  always_comb begin
    cp_ctx_t     s;
    cp_state_t   cls;
    cp_state_t   prior;
    logic        chg;
    logic        by_to;
    logic        rel;
    logic [7:0]  nd;
    logic [15:0] dly;

    s     = ctx_i;
    prior = ctx_i.current_state;
    chg   = 1'b0;
    by_to = 1'b0;

    cls = ctx_i.measured_state;
    if (item_i.pilot_peak >= cfg_i.thresh_a_b) begin
      cls = ST_A;
    end else if (item_i.pilot_peak >= cfg_i.thresh_b_c) begin
      cls = ST_B;
    end else if (item_i.pilot_peak >= cfg_i.thresh_c_d) begin
      cls = ST_C;
    end
    rel = item_i.pilot_peak >= cfg_i.thresh_b_c;

    nd = ctx_i.charge_duty;
    if (item_i.button_low) begin
      nd = cfg_i.duty_low_rate;
    end else if (item_i.button_mid) begin
      nd = cfg_i.duty_mid_rate;
    end else if (item_i.button_boost) begin
      nd = cfg_i.duty_boost_rate;
    end
    dly = (cls == ST_A) ? cfg_i.delay_to_a_ms : cfg_i.delay_other_ms;

    unique case (item_i.action)
      ACT_UPDATE: begin
        s.measured_state = cls;
        if (ctx_i.current_state == ST_SLEEP) begin
          if (rel || ((item_i.time_ms - ctx_i.sleep_start_ms) >= SLEEP_TO)) begin
            s.relay_state   = 1'b0;
            s.current_state = ST_B;
            chg             = 1'b1;
            by_to           = !rel;
          end
        end else begin
          s.charge_duty = nd;
          // duty only follows a button press that actually changes the rate
          if ((ctx_i.current_state == ST_C) && (nd != ctx_i.charge_duty)) begin
            s.duty_out = nd;
          end
          if (cls != ctx_i.current_state) begin
            if (cls != ctx_i.last_seen_state) begin
              s.last_seen_state = cls;
              if (cls != ctx_i.pending_state) begin
                s.pending_start_ms = item_i.time_ms;
                s.pending_state    = cls;
              end
            end else if (cls == ctx_i.pending_state) begin
              if ((item_i.time_ms - ctx_i.pending_start_ms) >= {16'd0, dly}) begin
                chg = 1'b1;
                if (cls == ST_A) begin
                  s.relay_state   = 1'b0;
                  s.duty_out      = FULL;
                  s.current_state = ST_A;
                end else if (cls == ST_B) begin
                  s.relay_state   = 1'b0;
                  s.duty_out      = ctx_i.charge_enabled ? nd : FULL;
                  s.current_state = ST_B;
                end else begin
                  s.relay_state   = ctx_i.charge_enabled;
                  s.duty_out      = ctx_i.charge_enabled ? nd : FULL;
                  s.current_state = ST_C;
                end
              end
            end else begin
              s.pending_start_ms = item_i.time_ms;
              s.pending_state    = cls;
            end
          end
        end
      end
      ACT_ENABLE: begin
        if (item_i.enable_value != ctx_i.charge_enabled) begin
          s.charge_enabled = item_i.enable_value;
          if (!item_i.enable_value) begin
            if (ctx_i.current_state == ST_C) begin
              s.duty_out       = FULL;
              s.sleep_start_ms = item_i.time_ms;
              s.current_state  = ST_SLEEP;
            end else if (ctx_i.current_state == ST_B) begin
              s.duty_out = FULL;
            end
          end else if (ctx_i.current_state == ST_SLEEP) begin
            s.duty_out      = ctx_i.charge_duty;
            s.relay_state   = 1'b0;
            s.current_state = ST_B;
          end else if (ctx_i.current_state == ST_B) begin
            s.duty_out = ctx_i.charge_duty;
          end else if (ctx_i.current_state == ST_C) begin
            s.duty_out    = ctx_i.charge_duty;
            s.relay_state = 1'b1;
          end
        end
      end
      ACT_SPEED: begin
        s.charge_duty = item_i.speed_value;
        if (ctx_i.current_state == ST_C) begin
          s.duty_out = item_i.speed_value;
        end
      end
      default: begin
      end
    endcase

    if (!chg) begin
      prior = s.current_state;
    end

    ctx_o                     = s;
    res_o.pwm_duty            = s.duty_out;
    res_o.relay_on            = s.relay_state;
    res_o.state_code          = s.current_state;
    res_o.changed             = chg;
    res_o.prior_state         = prior;
    res_o.released_by_timeout = by_to;
  end

endmodule
`default_nettype wire

FILE: rtl/core/ev_charger_pilot_state_machine_top.sv
// Pipeline: an accepted item passes through the input register, then the result
//   register; out_stall holds the result register and can stall the input.
// Throughput: one transaction per cycle while out_stall is low; the input register
//   refills, if empty, while a result waits under out_stall.
// Reset: synchronous active-low rst_n; registers return to defaults, pilot
//   state to A, duty constant high, relay open, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none
module ev_charger_pilot_state_machine_top import evcp_pkg::*; #(
  parameter int unsigned SLEEP_TIMEOUT_MS = SLEEP_TIMEOUT_MS_DEF,
  parameter int unsigned DUTY_FULL        = DUTY_FULL_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  cfg_t      cfg_r;
  cp_ctx_t   ctx_r;
  cp_ctx_t   ctx_nxt;
  out_item_t res_nxt;
  logic      advance;
  logic      in_take;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  evcp_step #(
    .SLEEP_TIMEOUT_MS(SLEEP_TIMEOUT_MS),
    .DUTY_FULL       (DUTY_FULL)
  ) u_step (
    .ctx_i (ctx_r),
    .cfg_i (cfg_r),
    .item_i(in_r),
    .ctx_o (ctx_nxt),
    .res_o (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r.current_state    <= ST_A;
      ctx_r.measured_state   <= ST_A;
      ctx_r.last_seen_state  <= ST_A;
      ctx_r.pending_state    <= ST_A;
      ctx_r.pending_start_ms <= '0;
      ctx_r.sleep_start_ms   <= '0;
      ctx_r.charge_duty      <= '0;
      ctx_r.charge_enabled   <= 1'b1;
      ctx_r.duty_out         <= 8'(DUTY_FULL);
      ctx_r.relay_state      <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        ctx_r       <= ctx_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh_a_b      <= THRESH_A_B_RST;
      cfg_r.thresh_b_c      <= THRESH_B_C_RST;
      cfg_r.thresh_c_d      <= THRESH_C_D_RST;
      cfg_r.delay_to_a_ms   <= DELAY_TO_A_RST;
      cfg_r.delay_other_ms  <= DELAY_OTHER_RST;
      cfg_r.duty_low_rate   <= DUTY_LOW_RST;
      cfg_r.duty_mid_rate   <= DUTY_MID_RST;
      cfg_r.duty_boost_rate <= DUTY_BOOST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESH_A_B:  cfg_r.thresh_a_b      <= cfg_data[11:0];
        CFG_THRESH_B_C:  cfg_r.thresh_b_c      <= cfg_data[11:0];
        CFG_THRESH_C_D:  cfg_r.thresh_c_d      <= cfg_data[11:0];
        CFG_DELAY_TO_A:  cfg_r.delay_to_a_ms   <= cfg_data;
        CFG_DELAY_OTHER: cfg_r.delay_other_ms  <= cfg_data;
        CFG_DUTY_LOW:    cfg_r.duty_low_rate   <= cfg_data[7:0];
        CFG_DUTY_MID:    cfg_r.duty_mid_rate   <= cfg_data[7:0];
        CFG_DUTY_BOOST:  cfg_r.duty_boost_rate <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while result stage can move");

  a_timeout_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.released_by_timeout) |->
      (out_r.changed && (out_r.prior_state == ST_SLEEP) && (out_r.state_code == ST_B)))
    else $error("timeout release without sleep exit to B");

  a_relay_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.relay_on) |->
      ((out_r.state_code == ST_C) || (out_r.state_code == ST_SLEEP)))
    else $error("relay closed outside state C or sleep");

  a_ctx_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ctx_r))
    else $error("pilot state changed without a transaction");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import evcp_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] DUTY_FULL = 8'(DUTY_FULL_DEF);
  localparam int BAND_A = 0;
  localparam int BAND_B = 1;
  localparam int BAND_C = 2;
  localparam int BAND_LOW = 3;
  localparam int LIMIT = 200000;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  out_item_t out_data;

  in_item_t charger_cmd_q[$];
  out_item_t expected_pilot_q[$];
  cp_ctx_t pilot_ctx;
  cfg_t pilot_regs;
  logic [31:0] gen_time = '0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;
  bit sender_hold = 1'b0;
  bit long_hold_req = 1'b0;

  ev_charger_pilot_state_machine_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cp_state_t classify_peak(logic [11:0] peak);
    if (peak >= pilot_regs.thresh_a_b) return ST_A;
    if (peak >= pilot_regs.thresh_b_c) return ST_B;
    if (peak >= pilot_regs.thresh_c_d) return ST_C;
    return pilot_ctx.measured_state;
  endfunction

  function automatic out_item_t predict_pilot_result(in_item_t it);
    out_item_t r;
    logic [7:0] nd;
    logic [31:0] elapsed;
    logic [31:0] debounce;
    logic chg;
    logic by_to;
    cp_state_t prior;
    chg = 1'b0;
    by_to = 1'b0;
    prior = pilot_ctx.current_state;
    case (it.action)
      ACT_UPDATE: begin
        if (pilot_ctx.current_state == ST_SLEEP) begin
          pilot_ctx.measured_state = classify_peak(it.pilot_peak);
          elapsed = it.time_ms - pilot_ctx.sleep_start_ms;
          if (it.pilot_peak >= pilot_regs.thresh_b_c || elapsed >= SLEEP_TIMEOUT_MS_DEF) begin
            pilot_ctx.relay_state = 1'b0;
            pilot_ctx.current_state = ST_B;
            chg = 1'b1;
            by_to = !(it.pilot_peak >= pilot_regs.thresh_b_c);
          end
        end else begin
          nd = pilot_ctx.charge_duty;
          if (it.button_low) nd = pilot_regs.duty_low_rate;
          else if (it.button_mid) nd = pilot_regs.duty_mid_rate;
          else if (it.button_boost) nd = pilot_regs.duty_boost_rate;
          if (nd != pilot_ctx.charge_duty) begin
            pilot_ctx.charge_duty = nd;
            if (pilot_ctx.current_state == ST_C) pilot_ctx.duty_out = nd;
          end
          pilot_ctx.measured_state = classify_peak(it.pilot_peak);
          if (pilot_ctx.measured_state != pilot_ctx.current_state) begin
            if (pilot_ctx.measured_state != pilot_ctx.last_seen_state) begin
              pilot_ctx.last_seen_state = pilot_ctx.measured_state;
              if (pilot_ctx.measured_state != pilot_ctx.pending_state) begin
                pilot_ctx.pending_start_ms = it.time_ms;
                pilot_ctx.pending_state = pilot_ctx.measured_state;
              end
            end else if (pilot_ctx.measured_state == pilot_ctx.pending_state) begin
              debounce = (pilot_ctx.measured_state == ST_A) ? pilot_regs.delay_to_a_ms
                                                            : pilot_regs.delay_other_ms;
              elapsed = it.time_ms - pilot_ctx.pending_start_ms;
              if (elapsed >= debounce) begin
                chg = 1'b1;
                case (pilot_ctx.measured_state)
                  ST_A: begin
                    pilot_ctx.relay_state = 1'b0;
                    pilot_ctx.duty_out = DUTY_FULL;
                    pilot_ctx.current_state = ST_A;
                  end
                  ST_B: begin
                    pilot_ctx.relay_state = 1'b0;
                    pilot_ctx.duty_out = pilot_ctx.charge_enabled ? pilot_ctx.charge_duty
                                                                  : DUTY_FULL;
                    pilot_ctx.current_state = ST_B;
                  end
                  default: begin
                    pilot_ctx.duty_out = pilot_ctx.charge_enabled ? pilot_ctx.charge_duty
                                                                  : DUTY_FULL;
                    pilot_ctx.relay_state = pilot_ctx.charge_enabled;
                    pilot_ctx.current_state = ST_C;
                  end
                endcase
              end
            end else begin
              pilot_ctx.pending_start_ms = it.time_ms;
              pilot_ctx.pending_state = pilot_ctx.measured_state;
            end
          end
        end
      end
      ACT_ENABLE: begin
        if (it.enable_value != pilot_ctx.charge_enabled) begin
          pilot_ctx.charge_enabled = it.enable_value;
          if (!it.enable_value) begin
            if (pilot_ctx.current_state == ST_C) begin
              pilot_ctx.duty_out = DUTY_FULL;
              pilot_ctx.sleep_start_ms = it.time_ms;
              pilot_ctx.current_state = ST_SLEEP;
            end else if (pilot_ctx.current_state == ST_B) begin
              pilot_ctx.duty_out = DUTY_FULL;
            end
          end else begin
            case (pilot_ctx.current_state)
              ST_SLEEP: begin
                pilot_ctx.duty_out = pilot_ctx.charge_duty;
                pilot_ctx.relay_state = 1'b0;
                pilot_ctx.current_state = ST_B;
              end
              ST_B: pilot_ctx.duty_out = pilot_ctx.charge_duty;
              ST_C: begin
                pilot_ctx.duty_out = pilot_ctx.charge_duty;
                pilot_ctx.relay_state = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      ACT_SPEED: begin
        pilot_ctx.charge_duty = it.speed_value;
        if (pilot_ctx.current_state == ST_C) pilot_ctx.duty_out = it.speed_value;
      end
      default: ;
    endcase
    if (!chg) prior = pilot_ctx.current_state;
    r.pwm_duty = pilot_ctx.duty_out;
    r.relay_on = pilot_ctx.relay_state;
    r.state_code = pilot_ctx.current_state;
    r.changed = chg;
    r.prior_state = prior;
    r.released_by_timeout = by_to;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_pilot_q.push_back(predict_pilot_result(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (charger_cmd_q.size() > 0 && !sender_hold) begin
          in_data <= charger_cmd_q.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pilot_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %h", $time, out_data);
          errors++;
        end else begin
          want = expected_pilot_q.pop_front();
          check_field("pwm_duty", want.pwm_duty, out_data.pwm_duty);
          check_field("relay_on", want.relay_on, out_data.relay_on);
          check_field("state_code", want.state_code, out_data.state_code);
          check_field("changed", want.changed, out_data.changed);
          check_field("prior_state", want.prior_state, out_data.prior_state);
          check_field("released_by_timeout", want.released_by_timeout,
                      out_data.released_by_timeout);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL ev_charger_pilot_state_machine_top");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESH_A_B: pilot_regs.thresh_a_b = val[11:0];
      CFG_THRESH_B_C: pilot_regs.thresh_b_c = val[11:0];
      CFG_THRESH_C_D: pilot_regs.thresh_c_d = val[11:0];
      CFG_DELAY_TO_A: pilot_regs.delay_to_a_ms = val;
      CFG_DELAY_OTHER: pilot_regs.delay_other_ms = val;
      CFG_DUTY_LOW: pilot_regs.duty_low_rate = val[7:0];
      CFG_DUTY_MID: pilot_regs.duty_mid_rate = val[7:0];
      default: pilot_regs.duty_boost_rate = val[7:0];
    endcase
  endtask

  task automatic program_regs(logic [15:0] a_b, logic [15:0] b_c, logic [15:0] c_d,
                              logic [15:0] to_a, logic [15:0] other,
                              logic [15:0] low, logic [15:0] mid, logic [15:0] boost);
    write_reg(CFG_THRESH_A_B, a_b);
    write_reg(CFG_THRESH_B_C, b_c);
    write_reg(CFG_THRESH_C_D, c_d);
    write_reg(CFG_DELAY_TO_A, to_a);
    write_reg(CFG_DELAY_OTHER, other);
    write_reg(CFG_DUTY_LOW, low);
    write_reg(CFG_DUTY_MID, mid);
    write_reg(CFG_DUTY_BOOST, boost);
  endtask

  function automatic void add_item(logic [1:0] act, logic [31:0] dt, logic [11:0] peak,
                                   logic [2:0] btn, logic en, logic [7:0] speed);
    in_item_t it;
    gen_time += dt;
    it.action = act;
    it.time_ms = gen_time;
    it.pilot_peak = peak;
    it.button_low = btn[2];
    it.button_mid = btn[1];
    it.button_boost = btn[0];
    it.enable_value = en;
    it.speed_value = speed;
    charger_cmd_q.push_back(it);
  endfunction

  function automatic void send_update(logic [31:0] dt, logic [11:0] peak, logic [2:0] btn);
    add_item(ACT_UPDATE, dt, peak, btn, 1'($urandom), 8'($urandom));
  endfunction

  function automatic void send_enable(logic [31:0] dt, logic en);
    add_item(ACT_ENABLE, dt, 12'($urandom), 3'($urandom), en, 8'($urandom));
  endfunction

  function automatic void send_speed(logic [31:0] dt, logic [7:0] speed);
    add_item(ACT_SPEED, dt, 12'($urandom), 3'($urandom), 1'($urandom), speed);
  endfunction

  function automatic logic [11:0] peak_in(int band);
    logic [11:0] lo;
    logic [11:0] hi;
    case (band)
      BAND_A: begin
        lo = pilot_regs.thresh_a_b;
        hi = 12'hFFF;
      end
      BAND_B: begin
        lo = pilot_regs.thresh_b_c;
        hi = (pilot_regs.thresh_a_b > lo) ? pilot_regs.thresh_a_b - 12'd1 : lo;
      end
      BAND_C: begin
        lo = pilot_regs.thresh_c_d;
        hi = (pilot_regs.thresh_b_c > lo) ? pilot_regs.thresh_b_c - 12'd1 : lo;
      end
      default: begin
        lo = '0;
        hi = (pilot_regs.thresh_c_d > 12'd0) ? pilot_regs.thresh_c_d - 12'd1 : 12'd0;
      end
    endcase
    if ($urandom_range(0, 3) == 0) return lo;
    return 12'($urandom_range(hi, lo));
  endfunction

  function automatic logic [2:0] rand_buttons();
    return {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 40);
      5, 6: return 32'(pilot_regs.delay_to_a_ms) + $urandom_range(0, 3);
      7: return 32'(pilot_regs.delay_other_ms) + $urandom_range(0, 3);
      8: return $urandom_range(0, 4000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] sleep_dt();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1000);
      1: return SLEEP_TIMEOUT_MS_DEF - 1;
      2: return SLEEP_TIMEOUT_MS_DEF;
      default: return SLEEP_TIMEOUT_MS_DEF + $urandom_range(0, 2000);
    endcase
  endfunction

  task automatic gen_random(int n);
    int made;
    int r;
    int len;
    int band;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        band = $urandom_range(BAND_A, BAND_LOW);
        len = $urandom_range(1, 6);
        repeat (len) send_update(pick_dt(), peak_in(band), rand_buttons());
        made += len;
      end else if (r < 60) begin
        send_enable(pick_dt(), 1'($urandom_range(0, 1)));
        made++;
      end else if (r < 68) begin
        send_speed(pick_dt(), 8'($urandom));
        made++;
      end else if (r < 72) begin
        add_item(ACT_NONE, $urandom_range(0, 50), 12'($urandom), 3'($urandom),
                 1'($urandom), 8'($urandom));
        made++;
      end else if (r < 87) begin
        // charge, pause into sleep, then leave by pilot rise, timeout or re-enable
        send_enable($urandom_range(0, 5), 1'b1);
        repeat (3) send_update(32'(pilot_regs.delay_other_ms) + $urandom_range(0, 3),
                               peak_in(BAND_C), rand_buttons());
        send_enable($urandom_range(0, 5), 1'b0);
        len = $urandom_range(1, 4);
        repeat (len) send_update(sleep_dt(), peak_in($urandom_range(BAND_C, BAND_LOW)),
                                 rand_buttons());
        if ($urandom_range(0, 1)) send_update(pick_dt(), peak_in($urandom_range(BAND_A, BAND_B)),
                                              rand_buttons());
        else send_enable($urandom_range(0, 100), 1'b1);
        made += len + 6;
      end else begin
        add_item(ACT_UPDATE, pick_dt(), 12'($urandom), 3'($urandom), 1'($urandom),
                 8'($urandom));
        made++;
      end
    end
  endtask

  task automatic drain();
    while (charger_cmd_q.size() != 0 || in_valid || expected_pilot_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    pilot_regs.thresh_a_b = THRESH_A_B_RST;
    pilot_regs.thresh_b_c = THRESH_B_C_RST;
    pilot_regs.thresh_c_d = THRESH_C_D_RST;
    pilot_regs.delay_to_a_ms = DELAY_TO_A_RST;
    pilot_regs.delay_other_ms = DELAY_OTHER_RST;
    pilot_regs.duty_low_rate = DUTY_LOW_RST;
    pilot_regs.duty_mid_rate = DUTY_MID_RST;
    pilot_regs.duty_boost_rate = DUTY_BOOST_RST;
    pilot_ctx = '0;
    pilot_ctx.charge_enabled = 1'b1;
    pilot_ctx.duty_out = DUTY_FULL;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_update(0, 12'hFFF, 3'b000);
    send_update(10, 12'h000, 3'b000);  // below lowest threshold, class held
    send_update(10, 12'd2200, 3'b100);
    send_update(50, 12'd2200, 3'b000);
    send_update(60, 12'd2200, 3'b000);
    send_speed(5, 8'hFF);              // duty follows at once in C
    send_update(5, 12'd2200, 3'b010);
    send_update(5, 12'd2200, 3'b001);
    send_enable(5, 1'b1);              // no change
    send_enable(5, 1'b0);              // C into sleep
    send_update(100, 12'd2200, 3'b111);
    send_speed(5, 8'h00);
    send_update(5, 12'd2600, 3'b000);  // pilot rise ends sleep
    send_enable(5, 1'b1);
    send_update(5, 12'd2200, 3'b000);
    send_update(100, 12'd2200, 3'b000);
    send_enable(5, 1'b0);
    send_enable(5, 1'b1);              // re-enable while sleeping
    send_update(5, 12'd2200, 3'b000);
    send_update(100, 12'd2200, 3'b000);
    send_enable(5, 1'b0);
    send_update(SLEEP_TIMEOUT_MS_DEF, 12'd100, 3'b000);
    send_update(5, 12'd2200, 3'b000);
    send_update(100, 12'd2200, 3'b000);
    send_speed(5, 8'd77);              // C while disabled
    gen_time = 32'hFFFF_FFC0;
    send_update(0, 12'hFFF, 3'b000);
    send_update(100, 12'hFFF, 3'b000); // debounce across time wrap
    add_item(ACT_NONE, 32'hFFFF_FFFF, 12'hFFF, 3'b111, 1'b1, 8'hFF);
    gen_random(300);
    drain();

    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gen_random(250);
    drain();

    program_regs(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    gen_random(150);
    drain();

    program_regs(16'($urandom_range(3000, 4095)) | 16'($urandom_range(0, 15) << 12),
                 16'($urandom_range(1500, 2999)) | 16'($urandom_range(0, 15) << 12),
                 16'($urandom_range(200, 1499)) | 16'($urandom_range(0, 15) << 12),
                 16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                 16'($urandom), 16'($urandom), 16'($urandom));
    gen_random(500);
    long_hold_req = 1'b1;
    while (charger_cmd_q.size() > 250) @(posedge clk);
    sender_hold = 1'b1;
    while (in_valid || expected_pilot_q.size() != 0) @(posedge clk);
    sender_hold = 1'b0;
    drain();

    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    gen_random(350);
    drain();

    idle_on = 1'b0;
    program_regs(16'(THRESH_A_B_RST), 16'(THRESH_B_C_RST), 16'(THRESH_C_D_RST),
                 16'($urandom_range(1, 50)), 16'($urandom_range(1, 50)),
                 16'($urandom), 16'($urandom), 16'($urandom));
    gen_time = 32'hFFFF_F000;
    gen_random(400);
    drain();

    if (errors == 0) begin
      $display("PASS ev_charger_pilot_state_machine_top");
    end else begin
      $display("FAIL ev_charger_pilot_state_machine_top");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/evcp_pkg.sv
rtl/core/evcp_step.sv
rtl/core/ev_charger_pilot_state_machine_top.sv
dv/tb_top.sv
